FILE: sv/rllh_pkg.sv
`timescale 1ns / 1ps
package rllh_pkg;
	localparam int TableDepth = 1024;
	localparam int IdxW = $clog2(TableDepth);
	localparam int NumBins = 32;
	localparam int BinW = 5;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_COMPLETE = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [2:0] ST_STARTED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_COUNTED = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_NEGATIVE = 3'd4;
	localparam logic [2:0] ST_READ = 3'd5;

	typedef struct packed {
		logic [1:0]      action;
		logic [63:0]     request_tag;
		logic [63:0]     time_now_ns;
		logic [BinW-1:0] bin_select;
	} in_item_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [BinW-1:0] bin_index;
		logic [31:0]     bin_count;
		logic [54:0]     latency_us;
	} out_item_t;

	// Classified work handed from the table front end to the histogram back end.
	typedef struct packed {
		logic            do_count;
		logic [2:0]      status;
		logic [63:0]     diff;
		logic [BinW-1:0] bin_select;
	} job_t;
endpackage

FILE: sv/request_latency_log2_histogram.sv
`timescale 1ns / 1ps
// A start of a new tag or an unknown-tag completion scans the whole tag table; a counted
// completion also rereads its entry and divides by 1000, and a read skips the table. A match
// ends the scan early.
// Throughput: one transaction at a time; busy stays high until the result cycle. The linear
// table scan makes one RAM read a cycle. The receiver cannot stall.
// Reset clears the histogram at once, then a pass invalidates every table entry, busy high.
module request_latency_log2_histogram (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rllh_pkg::in_item_t  in_item,
	output logic                busy,
	output logic                result_valid,
	output rllh_pkg::out_item_t result
);
	logic           job_valid;
	logic           job_ready;
	rllh_pkg::job_t job;
	logic           fbusy;

	// The front end holds an item until the back end takes its job, so one job queue
	// entry sits between them.
	rllh_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .in_item(in_item),
		.busy(fbusy), .job_valid(job_valid), .job(job), .job_ready(job_ready)
	);

	rllh_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_ready(job_ready), .result_valid(result_valid), .result(result)
	);

	// Also hold off new transactions while a job is pending or the back end still works on one.
	assign busy = fbusy || job_valid || !job_ready;

`ifndef NO_ASSERTIONS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == rllh_pkg::ST_STARTED
		|| result.status == rllh_pkg::ST_FULL || result.status == rllh_pkg::ST_COUNTED
		|| result.status == rllh_pkg::ST_UNKNOWN || result.status == rllh_pkg::ST_NEGATIVE
		|| result.status == rllh_pkg::ST_READ)) else $error("bad status");
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result held");
	a_lat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != rllh_pkg::ST_COUNTED) |-> result.latency_us == '0)
		else $error("latency without count");
`endif
endmodule

FILE: sv/rllh_ram.sv
`timescale 1ns / 1ps
module rllh_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/rllh_front.sv
`timescale 1ns / 1ps
module rllh_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  rllh_pkg::in_item_t    in_item,
	output logic                  busy,
	output logic                  job_valid,
	output rllh_pkg::job_t        job,
	input  logic                  job_ready
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [2:0] S_CLEAR = 3'd5;

	localparam int IW = rllh_pkg::IdxW;

	logic [2:0]          state_q;
	rllh_pkg::in_item_t  item_q;
	logic [IW:0]         ptr_q;
	logic                found_q;
	logic [IW-1:0]       hit_q;
	logic                have_free_q;
	logic [IW-1:0]       free_q;
	logic [IW-1:0]       rd_idx_q;
	logic                rd_pend_q;
	rllh_pkg::job_t      job_q;
	logic                jv_q;

	logic                we;
	logic [IW-1:0]       waddr;
	logic [128:0]        wdata;
	logic [128:0]        rdata;
	logic                tag_hit;

	// Each table entry holds its valid bit, the tag and the start time.
	rllh_ram #(.Width(129), .Depth(rllh_pkg::TableDepth)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(ptr_q[IW-1:0]), .rdata(rdata)
	);

	assign tag_hit = rd_pend_q && rdata[128] && (rdata[127:64] == item_q.request_tag);
	assign busy = (state_q != S_IDLE);
	assign job_valid = jv_q;
	assign job = job_q;

	always_comb begin
		we = 1'b0;
		waddr = found_q ? hit_q : free_q;
		wdata = {1'b0, item_q.request_tag, item_q.time_now_ns};
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = ptr_q[IW-1:0];
		end else if (state_q == S_WRITE && item_q.action == rllh_pkg::ACT_START
		    && (found_q || have_free_q)) begin
			we = 1'b1;
			wdata[128] = 1'b1;
		end else if (state_q == S_CHECK && rd_pend_q) begin
			// Frees the matching entry.
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			jv_q <= 1'b0;
			rd_pend_q <= 1'b0;
			found_q <= 1'b0;
			have_free_q <= 1'b0;
			ptr_q <= '0;
		end else begin
			if (jv_q && job_ready) jv_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					// One entry is invalidated per cycle after reset.
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q[IW-1:0] == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && in_item.action != rllh_pkg::ACT_NONE) begin
						item_q <= in_item;
						found_q <= 1'b0;
						have_free_q <= 1'b0;
						ptr_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= (in_item.action == rllh_pkg::ACT_READ) ? S_EMIT : S_SCAN;
					end
				end
				S_SCAN: begin
					// One RAM read per cycle; each entry is compared in the cycle after its read.
					rd_pend_q <= !ptr_q[IW];
					rd_idx_q <= ptr_q[IW-1:0];
					if (!ptr_q[IW]) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (rd_pend_q && !rdata[128] && !have_free_q) begin
						have_free_q <= 1'b1;
						free_q <= rd_idx_q;
					end
					if (tag_hit) begin
						found_q <= 1'b1;
						hit_q <= rd_idx_q;
						state_q <= S_WRITE;
					end else if (ptr_q[IW] && !rd_pend_q) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					job_q.diff <= item_q.time_now_ns - rdata[63:0];
					job_q.do_count <= 1'b0;
					job_q.bin_select <= item_q.bin_select;
					if (item_q.action == rllh_pkg::ACT_START) begin
						if (found_q || have_free_q) begin
							job_q.status <= rllh_pkg::ST_STARTED;
						end else begin
							job_q.status <= rllh_pkg::ST_FULL;
						end
						state_q <= S_EMIT;
					end else if (!found_q) begin
						job_q.status <= rllh_pkg::ST_UNKNOWN;
						state_q <= S_EMIT;
					end else begin
						ptr_q <= {1'b0, hit_q};
						rd_pend_q <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// Reread the matching entry to get its start time.
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						job_q.diff <= item_q.time_now_ns - rdata[63:0];
						job_q.do_count <= 1'b1;
						job_q.status <= rllh_pkg::ST_COUNTED;
						state_q <= S_EMIT;
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (!jv_q || job_ready) begin
						if (item_q.action == rllh_pkg::ACT_READ) begin
							jv_q <= 1'b1;
							job_q.do_count <= 1'b0;
							job_q.status <= rllh_pkg::ST_READ;
							job_q.bin_select <= item_q.bin_select;
							job_q.diff <= '0;
						end else begin
							jv_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/rllh_back.sv
`timescale 1ns / 1ps
module rllh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  rllh_pkg::job_t      job,
	output logic                job_ready,
	output logic                result_valid,
	output rllh_pkg::out_item_t result
);
	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV = 2'd1;
	localparam logic [1:0] B_BIN = 2'd2;
	localparam logic [1:0] B_OUT = 2'd3;

	// 2^36 / 1000 rounded up; the product gives the exact quotient for dividends below 2^26.
	localparam logic [26:0] NsRecip = 27'd68719477;
	localparam logic [25:0] NsPerUs = 26'd1000;

	logic [1:0]          state_q;
	logic [9:0]          rem_q;
	logic [63:0]         quo_q;
	logic [1:0]          cnt_q;
	logic [31:0]         bins_q [rllh_pkg::NumBins];
	logic                rv_q;
	rllh_pkg::out_item_t res_q;
	logic [25:0]         dvd;
	logic [52:0]         prod;
	logic [15:0]         qdig;
	logic [9:0]          rest;
	logic [4:0]          lg;

	assign job_ready = (state_q == B_IDLE);
	assign result_valid = rv_q;
	assign result = res_q;

	// Long division by 1000, sixteen dividend bits per cycle: the running remainder and
	// the next chunk are divided by a reciprocal multiply.
	assign dvd = {rem_q, quo_q[63:48]};
	assign prod = {27'd0, dvd} * {26'd0, NsRecip};
	assign qdig = 16'(prod >> 36);
	assign rest = 10'(dvd - {10'd0, qdig} * NsPerUs);

	always_comb begin
		lg = '0;
		for (int i = 1; i < 64; i++) begin
			if (quo_q[i]) lg = (i > rllh_pkg::NumBins - 1) ? 5'(rllh_pkg::NumBins - 1) : 5'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rv_q <= 1'b0;
			for (int i = 0; i < rllh_pkg::NumBins; i++) bins_q[i] <= '0;
		end else begin
			rv_q <= (state_q == B_OUT);
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						if (job.do_count && !job.diff[63]) begin
							res_q <= '{status: job.status, bin_index: '0, bin_count: '0,
								latency_us: '0};
							quo_q <= job.diff;
							rem_q <= '0;
							cnt_q <= '0;
							state_q <= B_DIV;
						end else if (job.do_count) begin
							res_q <= '{status: rllh_pkg::ST_NEGATIVE, bin_index: '0,
								bin_count: '0, latency_us: '0};
							state_q <= B_OUT;
						end else if (job.status == rllh_pkg::ST_READ) begin
							res_q <= '{status: job.status, bin_index: job.bin_select,
								bin_count: bins_q[job.bin_select], latency_us: '0};
							state_q <= B_OUT;
						end else begin
							res_q <= '{status: job.status, bin_index: '0, bin_count: '0,
								latency_us: '0};
							state_q <= B_OUT;
						end
					end
				end
				B_DIV: begin
					quo_q <= {quo_q[47:0], qdig};
					rem_q <= rest;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) state_q <= B_BIN;
				end
				B_BIN: begin
					if (bins_q[lg] != 32'hFFFF_FFFF) begin
						bins_q[lg] <= bins_q[lg] + 1'b1;
						res_q.bin_count <= bins_q[lg] + 1'b1;
					end else begin
						res_q.bin_count <= bins_q[lg];
					end
					res_q.bin_index <= lg;
					res_q.latency_us <= quo_q[54:0];
					state_q <= B_OUT;
				end
				B_OUT: begin
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

FILE: sim/tb_request_latency_log2_histogram.sv
`timescale 1ns / 1ps
// Self-checking bench for the request latency histogram.
// A scoreboard class keeps its own copy of the tag table and the bins, predicts the
// single result of every accepted transaction but the unused action and checks results in order.
module tb_request_latency_log2_histogram;

	// Scoreboard: shadow tag table, shadow histogram and the queue of pending results.
	class latency_scoreboard;
		bit                  slot_used [rllh_pkg::TableDepth];
		logic [63:0]         slot_tag  [rllh_pkg::TableDepth];
		logic [63:0]         slot_time [rllh_pkg::TableDepth];
		logic [31:0]         bin_total [rllh_pkg::NumBins];
		rllh_pkg::out_item_t pending_results[$];
		int                  mismatches;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			foreach (bin_total[i]) bin_total[i] = '0;
			mismatches = 0;
		endfunction

		function int occupancy();
			int n;
			n = 0;
			foreach (slot_used[i]) if (slot_used[i]) n++;
			return n;
		endfunction

		// Lowest slot holding the tag, or -1.
		function int lookup(logic [63:0] tag);
			foreach (slot_used[i]) if (slot_used[i] && slot_tag[i] == tag) return i;
			return -1;
		endfunction

		// Updates the shadow state for one accepted transaction and queues its result.
		function void record_request(rllh_pkg::in_item_t req);
			rllh_pkg::out_item_t res;
			int                  slot;
			logic [63:0]         diff;
			logic [63:0]         usec;
			logic [63:0]         v;
			int                  bin;
			res = '0;
			case (req.action)
				rllh_pkg::ACT_START: begin
					slot = lookup(req.request_tag);
					if (slot < 0)
						foreach (slot_used[i]) if (!slot_used[i] && slot < 0) slot = i;
					if (slot < 0) begin
						res.status = rllh_pkg::ST_FULL;
					end else begin
						slot_used[slot] = 1'b1;
						slot_tag[slot]  = req.request_tag;
						slot_time[slot] = req.time_now_ns;
						res.status = rllh_pkg::ST_STARTED;
					end
				end
				rllh_pkg::ACT_COMPLETE: begin
					slot = lookup(req.request_tag);
					if (slot < 0) begin
						res.status = rllh_pkg::ST_UNKNOWN;
					end else begin
						diff = req.time_now_ns - slot_time[slot];
						slot_used[slot] = 1'b0;
						if (diff[63]) begin
							res.status = rllh_pkg::ST_NEGATIVE;
						end else begin
							usec = diff / 64'd1000;
							bin = 0;
							v = usec;
							while (v > 1) begin
								v = v >> 1;
								bin++;
							end
							if (bin >= rllh_pkg::NumBins) bin = rllh_pkg::NumBins - 1;
							if (bin_total[bin] != 32'hFFFF_FFFF) bin_total[bin]++;
							res.status     = rllh_pkg::ST_COUNTED;
							res.bin_index  = bin[4:0];
							res.bin_count  = bin_total[bin];
							res.latency_us = usec[54:0];
						end
					end
				end
				rllh_pkg::ACT_READ: begin
					res.status    = rllh_pkg::ST_READ;
					res.bin_index = req.bin_select;
					res.bin_count = (req.bin_select < rllh_pkg::NumBins) ?
						bin_total[req.bin_select] : '0;
				end
				default: return;  // the unused action produces no result
			endcase
			pending_results.push_back(res);
		endfunction

		function void check_result(rllh_pkg::out_item_t got);
			rllh_pkg::out_item_t exp;
			if (pending_results.size() == 0) begin
				$error("result with no transaction pending: %p", got);
				mismatches++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				mismatches++;
			end
			if (got.bin_index !== exp.bin_index) begin
				$error("bin_index: expected %0d, actual %0d", exp.bin_index, got.bin_index);
				mismatches++;
			end
			if (got.bin_count !== exp.bin_count) begin
				$error("bin_count: expected %0d, actual %0d", exp.bin_count, got.bin_count);
				mismatches++;
			end
			if (got.latency_us !== exp.latency_us) begin
				$error("latency_us: expected %0d, actual %0d", exp.latency_us, got.latency_us);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	rllh_pkg::in_item_t  in_item;
	logic                busy;
	logic                result_valid;
	rllh_pkg::out_item_t result;

	latency_scoreboard sb;

	// Tags used by the random part, with the start time most recently issued for each,
	// so that completions can be aimed at chosen latencies.
	logic [63:0] tag_pool   [16];
	logic [63:0] pool_start [16];
	bit          no_idle;

	request_latency_log2_histogram u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.in_item     (in_item),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Results live for one cycle only, so every strobe is checked at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Presents one transaction after a random gap and holds it until the block takes it.
	// The gap is drawn per item; some stretches run with no gaps at all.
	task automatic issue(logic [1:0] act, logic [63:0] tag, logic [63:0] now, logic [4:0] sel);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item.action      = act;
		in_item.request_tag = tag;
		in_item.time_now_ns = now;
		in_item.bin_select  = sel;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sb.record_request(in_item);
	endtask

	// Holds the sender off until every pending result has been seen.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
	endtask

	initial begin
		int          k;
		int          pick;
		int          roll;
		logic [63:0] span;
		logic [63:0] base;

		sb = new();
		no_idle = 1'b0;
		start   = 1'b0;
		in_item = '0;
		arst_n  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: field extremes, every action and the special cases.
		issue(rllh_pkg::ACT_READ, '0, '0, 5'd0);
		issue(rllh_pkg::ACT_READ, '1, '1, 5'd31);
		issue(rllh_pkg::ACT_COMPLETE, 64'h1234, 64'd5000, '0);        // unknown tag
		issue(rllh_pkg::ACT_START, '0, '0, '0);
		issue(rllh_pkg::ACT_COMPLETE, '0, 64'd999, '0);       // below one microsecond, bin 0
		issue(rllh_pkg::ACT_START, '1, 64'd1000, '1);
		issue(rllh_pkg::ACT_START, '1, 64'd2000, '0);         // same tag again: time overwritten
		issue(rllh_pkg::ACT_COMPLETE, '1, 64'd4000, '0);      // 2 us, bin 1
		issue(rllh_pkg::ACT_START, 64'hA5A5_5A5A_0F0F_F0F0, 64'd100_000, '0);
		issue(rllh_pkg::ACT_COMPLETE, 64'hA5A5_5A5A_0F0F_F0F0, 64'd99_999, '0);  // negative
		issue(rllh_pkg::ACT_COMPLETE, 64'hA5A5_5A5A_0F0F_F0F0, 64'd200_000, '0); // already freed
		issue(rllh_pkg::ACT_START, 64'd7, '0, '0);
		issue(rllh_pkg::ACT_COMPLETE, 64'd7, 64'h7FFF_FFFF_FFFF_FFFF, '0); // largest latency
		issue(rllh_pkg::ACT_START, 64'd8, '1, '0);
		issue(rllh_pkg::ACT_COMPLETE, 64'd8, 64'h7FFF_FFFF_FFFF_FFFE, '0); // wraps to top positive
		issue(rllh_pkg::ACT_START, 64'd9, 64'h8000_0000_0000_0000, '0);
		issue(rllh_pkg::ACT_COMPLETE, 64'd9, '0, '0);         // difference of exactly minus 2^63
		issue(rllh_pkg::ACT_NONE, '1, '1, '1);                // unused action, no result
		issue(rllh_pkg::ACT_READ, '0, '0, 5'd1);
		issue(rllh_pkg::ACT_READ, '0, '0, 5'd30);
		drain();

		// Random part: mostly start and completion pairs on a small tag pool.
		foreach (tag_pool[i]) begin
			tag_pool[i]   = rand64();
			pool_start[i] = rand64();
		end
		for (k = 0; k < 150; k++) begin
			if (k % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if (k == 75) drain();
			pick = $urandom_range(0, 15);
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				pool_start[pick] = rand64();
				issue(rllh_pkg::ACT_START, tag_pool[pick], pool_start[pick], 5'($urandom()));
			end else if (roll < 80) begin
				// Spread latencies over all bins; a few land before the start time.
				span = rand64() >> $urandom_range(1, 63);
				if ($urandom_range(0, 9) == 0)
					issue(rllh_pkg::ACT_COMPLETE, tag_pool[pick], pool_start[pick] - span - 1,
						5'($urandom()));
				else
					issue(rllh_pkg::ACT_COMPLETE, tag_pool[pick], pool_start[pick] + span,
						5'($urandom()));
			end else if (roll < 82) begin
				issue(rllh_pkg::ACT_COMPLETE, rand64(), rand64(), 5'($urandom()));
			end else if (roll < 96) begin
				issue(rllh_pkg::ACT_READ, rand64(), rand64(), 5'($urandom()));
			end else begin
				issue(rllh_pkg::ACT_NONE, rand64(), rand64(), 5'($urandom()));
			end
		end

		// Fill the table to the brim, then probe the full behavior.
		no_idle = 1'b1;
		base = rand64() & 64'hFFFF_FFFF_FFFF_0000;
		k = 0;
		while (sb.occupancy() < rllh_pkg::TableDepth) begin
			issue(rllh_pkg::ACT_START, base + k, rand64(), 5'($urandom()));
			k++;
		end
		no_idle = 1'b0;
		issue(rllh_pkg::ACT_START, ~base, rand64(), '0);              // dropped, table full
		issue(rllh_pkg::ACT_START, base, 64'd10_000, '0);             // present tag still overwrites
		issue(rllh_pkg::ACT_COMPLETE, base, 64'd50_000, '0);
		issue(rllh_pkg::ACT_START, ~base, 64'd1, '0);                 // takes the slot just freed
		issue(rllh_pkg::ACT_START, ~base + 1, 64'd1, '0);             // full again
		issue(rllh_pkg::ACT_COMPLETE, ~base, 64'd1_000_001, '0);
		issue(rllh_pkg::ACT_READ, '0, '0, 5'd5);

		drain();
		repeat (2000) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("request_latency_log2_histogram regression: pass");
		else
			$display("request_latency_log2_histogram regression: fail");
		$finish;
	end

	// Watchdog: a start or completion can walk the whole table, so the bound is wide.
	initial begin
		#60_000_000;
		$display("request_latency_log2_histogram regression: fail");
		$finish;
	end
endmodule

FILE: filelist.f
sv/rllh_pkg.sv
sv/rllh_ram.sv
sv/rllh_front.sv
sv/rllh_back.sv
sv/request_latency_log2_histogram.sv
sim/tb_request_latency_log2_histogram.sv
